/* hw/rtl/outward_fractional_shift_splat_defines.svh */
// ----------------------------------------------------------------------------
// outward_fractional_shift_splat_defines.svh
// Assertion macros shared by the splat block. Clock is clk, reset is rst_n.
// ----------------------------------------------------------------------------
`ifndef OUTWARD_FRACTIONAL_SHIFT_SPLAT_DEFINES_SVH
`define OUTWARD_FRACTIONAL_SHIFT_SPLAT_DEFINES_SVH

// same-cycle implication
`define OFSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OFSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ofss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofss_pkg
// Widths, codes, pixel type and helpers for the outward shift splat block.
// ----------------------------------------------------------------------------
package ofss_pkg;

  localparam int STRIP_PIXELS_DEF = 256;

  localparam int IDX_W      = 8;
  localparam int COLOUR_W   = 16;
  localparam int SHIFT_W    = 16;
  localparam int GAIN_W     = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int FRAC_W     = 8;
  localparam int TGT_W      = 18;  // signed Q10.8 target position
  localparam int LOWER_W    = 10;  // signed floor of the target
  localparam int WEIGHT_W   = 25;  // Q24 weight, up to exactly 1.0
  localparam int WFULL_W    = GAIN_W + FRAC_W + 1;
  localparam int PROD_W     = COLOUR_W + WEIGHT_W;
  localparam int WFRAC_W    = 24;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'h10000;
  localparam logic [PROD_W-1:0] ROUND_HALF = 41'h0000_0800000;
  localparam logic [FRAC_W:0]   ONE_PIXEL  = 9'h100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT = 1'b0,
    REG_GAIN  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_SPLAT = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } rgb_t;

  function automatic logic [COLOUR_W-1:0] sat_add(input logic [COLOUR_W-1:0] a,
                                                  input logic [COLOUR_W-1:0] b);
    logic [COLOUR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COLOUR_W] ? {COLOUR_W{1'b1}} : s[COLOUR_W-1:0];
  endfunction

  function automatic rgb_t rgb_sat_add(input rgb_t a, input rgb_t b);
    rgb_t r;
    r.red   = sat_add(a.red, b.red);
    r.green = sat_add(a.green, b.green);
    r.blue  = sat_add(a.blue, b.blue);
    return r;
  endfunction

endpackage

/* hw/rtl/ofss_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ofss_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/ofss_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofss_mac
// Weights one pixel: each colour times a Q24 weight, rounded half up, registered.
// ----------------------------------------------------------------------------
module ofss_mac (
  input  logic                                  clk,
  input  ofss_pkg::rgb_t                        colour,
  input  logic [ofss_pkg::WEIGHT_W-1:0]         weight,
  output ofss_pkg::rgb_t                        part
);

  localparam int LSB = ofss_pkg::WFRAC_W;
  localparam int MSB = ofss_pkg::WFRAC_W + ofss_pkg::COLOUR_W - 1;

  logic [ofss_pkg::PROD_W-1:0] w_ext;
  logic [ofss_pkg::PROD_W-1:0] prod_red, prod_green, prod_blue;
  ofss_pkg::rgb_t              part_r;

  assign w_ext = ofss_pkg::PROD_W'(weight);

  // product never exceeds 65535.5 after rounding, so the top bit stays clear
  assign prod_red   = ofss_pkg::PROD_W'(colour.red)   * w_ext + ofss_pkg::ROUND_HALF;
  assign prod_green = ofss_pkg::PROD_W'(colour.green) * w_ext + ofss_pkg::ROUND_HALF;
  assign prod_blue  = ofss_pkg::PROD_W'(colour.blue)  * w_ext + ofss_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    part_r.red   <= prod_red[MSB:LSB];
    part_r.green <= prod_green[MSB:LSB];
    part_r.blue  <= prod_blue[MSB:LSB];
  end

  assign part = part_r;

endmodule

/* hw/rtl/outward_fractional_shift_splat.sv */
`timescale 1ns / 1ps
// Splat steps: weight, lower product, lower write-back with upper product,
// upper write-back, idle; a new word is taken only in idle (single RAM write port).
// Read steps: read address, read data; out_strobe is registered from read data.
// Reset: synchronous, active low; then a clearing pass zeroes every address of
// the frame store with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
// outward_fractional_shift_splat
// Fractional outward shift of an LED strip frame into a saturating frame store.
// ----------------------------------------------------------------------------
`include "outward_fractional_shift_splat_defines.svh"

module outward_fractional_shift_splat #(
  parameter int STRIP_PIXELS = ofss_pkg::STRIP_PIXELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ofss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ofss_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_operation,
  input  logic [ofss_pkg::IDX_W-1:0]        in_pixel_index,
  input  logic [ofss_pkg::COLOUR_W-1:0]     in_red_in,
  input  logic [ofss_pkg::COLOUR_W-1:0]     in_green_in,
  input  logic [ofss_pkg::COLOUR_W-1:0]     in_blue_in,
  output logic                              out_strobe,
  output logic [ofss_pkg::IDX_W-1:0]        out_pixel_out_index,
  output logic [ofss_pkg::COLOUR_W-1:0]     out_red_out,
  output logic [ofss_pkg::COLOUR_W-1:0]     out_green_out,
  output logic [ofss_pkg::COLOUR_W-1:0]     out_blue_out
);

  localparam int ADDR_W = $clog2(STRIP_PIXELS);
  localparam int CMP_W  = (ADDR_W >= ofss_pkg::LOWER_W) ? ADDR_W + 1 : ofss_pkg::LOWER_W;
  localparam logic [CMP_W-1:0]  STRIP_LIM = CMP_W'(STRIP_PIXELS);
  localparam logic [CMP_W-1:0]  HALF_LIM  = CMP_W'(STRIP_PIXELS / 2);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STRIP_PIXELS - 1);
  localparam int LW = ofss_pkg::LOWER_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WEIGHT,
    ST_LO,
    ST_HI,
    ST_HI_WB,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  state_t                              state_r, state_nxt;
  logic [ADDR_W-1:0]                   clr_cnt_r, clr_cnt_nxt;
  logic [ofss_pkg::SHIFT_W-1:0]        shift_r, shift_nxt;
  logic [ofss_pkg::GAIN_W-1:0]         gain_r, gain_nxt;

  ofss_pkg::op_t                       op_r, op_nxt;
  logic [ofss_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  ofss_pkg::rgb_t                      col_r, col_nxt;
  logic [LW-1:0]                       lower_r, lower_nxt;
  logic [ofss_pkg::FRAC_W-1:0]         frac_r, frac_nxt;
  logic [ofss_pkg::WEIGHT_W-1:0]       w_lo_r, w_lo_nxt, w_hi_r, w_hi_nxt;

  logic                                out_strobe_r, out_strobe_nxt;
  logic [ofss_pkg::IDX_W-1:0]          out_idx_r, out_idx_nxt;
  ofss_pkg::rgb_t                      out_col_r, out_col_nxt;

  logic                                accept;
  logic                                left_half;
  logic [ofss_pkg::TGT_W-1:0]          tgt;
  logic [ofss_pkg::TGT_W-1:0]          in_pos;
  logic [ofss_pkg::WFULL_W-1:0]        wl_full, wu_full, gain_ext;
  logic [LW-1:0]                       upper;
  logic [CMP_W-1:0]                    lo_cmp, hi_cmp, idx_cmp;
  logic                                lo_ok, hi_ok, idx_ok;
  logic [ADDR_W-1:0]                   lo_addr, hi_addr, idx_addr;

  logic                                mem_we;
  logic [ADDR_W-1:0]                   mem_waddr, mem_raddr;
  ofss_pkg::rgb_t                      mem_wdata, mem_rdata;
  logic [$bits(ofss_pkg::rgb_t)-1:0]   mem_rdata_raw;
  logic [ofss_pkg::WEIGHT_W-1:0]       mac_weight;
  ofss_pkg::rgb_t                      part;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // target in signed Q10.8; floor and fraction come straight from two's complement bits
  assign left_half = (CMP_W'(in_pixel_index) < HALF_LIM);
  assign in_pos    = ofss_pkg::TGT_W'({in_pixel_index, 8'h00});
  assign tgt       = left_half ? (in_pos - ofss_pkg::TGT_W'(shift_r))
                               : (in_pos + ofss_pkg::TGT_W'(shift_r));

  assign gain_ext = ofss_pkg::WFULL_W'(gain_r);
  assign wl_full  = ofss_pkg::WFULL_W'(ofss_pkg::ONE_PIXEL - {1'b0, frac_r}) * gain_ext;
  assign wu_full  = ofss_pkg::WFULL_W'(frac_r) * gain_ext;

  assign upper    = lower_r + LW'(1);
  assign lo_cmp   = CMP_W'(lower_r[LW-2:0]);
  assign hi_cmp   = CMP_W'(upper[LW-2:0]);
  assign idx_cmp  = CMP_W'(idx_r);
  assign lo_ok    = !lower_r[LW-1] && (lo_cmp < STRIP_LIM);
  assign hi_ok    = !upper[LW-1] && (hi_cmp < STRIP_LIM);
  assign idx_ok   = (idx_cmp < STRIP_LIM);
  assign lo_addr  = lo_cmp[ADDR_W-1:0];
  assign hi_addr  = hi_cmp[ADDR_W-1:0];
  assign idx_addr = idx_cmp[ADDR_W-1:0];

  assign mac_weight = (state_r == ST_HI) ? w_hi_r : w_lo_r;

  ofss_mac u_mac (
    .clk    (clk),
    .colour (col_r),
    .weight (mac_weight),
    .part   (part)
  );

  ofss_ram #(
    .WIDTH ($bits(ofss_pkg::rgb_t)),
    .DEPTH (STRIP_PIXELS)
  ) u_frame (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  assign mem_rdata = ofss_pkg::rgb_t'(mem_rdata_raw);

  always_comb begin
    case (state_r)
      ST_LO:   mem_raddr = lo_addr;
      ST_HI:   mem_raddr = hi_addr;
      default: mem_raddr = idx_addr;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_addr;
    mem_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      ST_HI: begin
        mem_we    = lo_ok;
        mem_waddr = lo_addr;
        mem_wdata = ofss_pkg::rgb_sat_add(mem_rdata, part);
      end
      ST_HI_WB: begin
        mem_we    = hi_ok;
        mem_waddr = hi_addr;
        mem_wdata = ofss_pkg::rgb_sat_add(mem_rdata, part);
      end
      ST_RD_DATA: begin
        // read clears the pixel
        mem_we    = idx_ok;
        mem_waddr = idx_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    shift_nxt      = shift_r;
    gain_nxt       = gain_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    col_nxt        = col_r;
    lower_nxt      = lower_r;
    frac_nxt       = frac_r;
    w_lo_nxt       = w_lo_r;
    w_hi_nxt       = w_hi_r;
    out_strobe_nxt = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_col_nxt    = out_col_r;

    if (cfg_we) begin
      if (cfg_index == ofss_pkg::REG_SHIFT) begin
        shift_nxt = cfg_data[ofss_pkg::SHIFT_W-1:0];
      end else begin
        // gains above one behave as one
        gain_nxt = (cfg_data > ofss_pkg::GAIN_ONE) ? ofss_pkg::GAIN_ONE : cfg_data;
      end
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = ofss_pkg::op_t'(in_operation);
          idx_nxt   = in_pixel_index;
          col_nxt   = '{red: in_red_in, green: in_green_in, blue: in_blue_in};
          lower_nxt = tgt[ofss_pkg::TGT_W-1:ofss_pkg::FRAC_W];
          frac_nxt  = tgt[ofss_pkg::FRAC_W-1:0];
          if (in_operation == ofss_pkg::OP_READ) begin
            state_nxt = ST_RD_ADDR;
          end else if (CMP_W'(in_pixel_index) < STRIP_LIM) begin
            state_nxt = ST_WEIGHT;
          end
        end
      end
      ST_WEIGHT: begin
        w_lo_nxt  = wl_full[ofss_pkg::WEIGHT_W-1:0];
        w_hi_nxt  = wu_full[ofss_pkg::WEIGHT_W-1:0];
        state_nxt = ST_LO;
      end
      ST_LO:      state_nxt = ST_HI;
      ST_HI:      state_nxt = ST_HI_WB;
      ST_HI_WB:   state_nxt = ST_IDLE;
      ST_RD_ADDR: state_nxt = ST_RD_DATA;
      ST_RD_DATA: begin
        out_strobe_nxt = (op_r == ofss_pkg::OP_READ);
        out_idx_nxt    = idx_r;
        out_col_nxt    = idx_ok ? mem_rdata : '0;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      shift_r      <= '0;
      gain_r       <= ofss_pkg::GAIN_ONE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      shift_r      <= shift_nxt;
      gain_r       <= gain_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    col_r     <= col_nxt;
    lower_r   <= lower_nxt;
    frac_r    <= frac_nxt;
    w_lo_r    <= w_lo_nxt;
    w_hi_r    <= w_hi_nxt;
    out_idx_r <= out_idx_nxt;
    out_col_r <= out_col_nxt;
  end

  assign out_strobe          = out_strobe_r;
  assign out_pixel_out_index = out_idx_r;
  assign out_red_out         = out_col_r.red;
  assign out_green_out       = out_col_r.green;
  assign out_blue_out        = out_col_r.blue;

  `OFSS_ASSERT_NEXT(a_strobe_only_after_read, state_r != ST_RD_DATA, !out_strobe_r, "strobe without read")
  `OFSS_ASSERT_NEXT(a_offstrip_read_zero, (state_r == ST_RD_DATA) && !idx_ok, out_col_r == '0, "off-strip read not zero")
  `OFSS_ASSERT_IMPL(a_lo_hi_no_overlap, (state_r == ST_HI) && mem_we, mem_waddr != mem_raddr, "lower write hits upper read")
  `OFSS_ASSERT_NEXT(a_clear_done, (state_r == ST_CLEAR) && (clr_cnt_r == LAST_ADDR), state_r == ST_IDLE, "clear pass overrun")

endmodule
